// ===== design/tlk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlk_pkg
// Shared types and constants for the tree ancestor / path node block.
// ----------------------------------------------------------------------------
package tlk_pkg;

   localparam int NODE_W = 16;
   localparam int AMT_W  = 17;   // lift amounts up to twice a 16-bit depth
   localparam int LVL_W  = 5;    // holds any level index below 32

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_LCA  = 2'd1;
   localparam logic [1:0] MODE_PATH = 2'd2;

   typedef struct packed {
      logic              anc_rd;
      logic              dep_rd;
      logic [NODE_W-1:0] rd_node;
      logic [LVL_W-1:0]  rd_lvl;
      logic              anc_wr;
      logic              dep_wr;
      logic [NODE_W-1:0] wr_node;
      logic [LVL_W-1:0]  wr_lvl;
      logic [NODE_W-1:0] anc_wdata;
      logic [NODE_W-1:0] dep_wdata;
   } mem_req_type;

   typedef struct packed {
      logic [NODE_W-1:0] anc_data;
      logic [NODE_W-1:0] dep_data;
   } mem_rsp_type;

endpackage
`default_nettype wire

// ===== design/tlk_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlk_req_if / tlk_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface tlk_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] node_u;
   logic [15:0] node_v;
   logic [15:0] offset_k;
   modport source (output valid, mode, node_u, node_v, offset_k, input ready);
   modport sink   (input valid, mode, node_u, node_v, offset_k, output ready);
endinterface

interface tlk_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result_node;
   logic        out_of_range;
   modport source (output valid, result_node, out_of_range, input ready);
   modport sink   (input valid, result_node, out_of_range, output ready);
endinterface
`default_nettype wire

// ===== design/tlk_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlk_mem
// Ancestor table and depth store, one read port and one write port each,
// registered read data. Node zero and nodes beyond the table read as zero.
// ----------------------------------------------------------------------------
module tlk_mem import tlk_pkg::*; #(
   parameter int NODES  = 65536,
   parameter int LEVELS = 16
) (
   input  wire logic        clock,
   input  wire mem_req_type req,
   output mem_rsp_type      rsp
);
   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   logic [NODE_W-1:0] anc_mem [NODES][LEVELS];
   logic [NODE_W-1:0] dep_mem [NODES];
   logic [NODE_W-1:0] anc_q_ff, dep_q_ff;
   logic              anc_zero_ff, dep_zero_ff;
   logic              rd_bad;

   assign rd_bad = (req.rd_node == '0) || (32'(req.rd_node) >= 32'(NODES));

   always_ff @(posedge clock) begin
      if (req.anc_wr) begin
         anc_mem[NW'(req.wr_node)][LW'(req.wr_lvl)] <= req.anc_wdata;
      end
      if (req.dep_wr) begin
         dep_mem[NW'(req.wr_node)] <= req.dep_wdata;
      end
      if (req.anc_rd) begin
         anc_q_ff    <= anc_mem[NW'(req.rd_node)][LW'(req.rd_lvl)];
         anc_zero_ff <= rd_bad;
      end
      if (req.dep_rd) begin
         dep_q_ff    <= dep_mem[NW'(req.rd_node)];
         dep_zero_ff <= rd_bad;
      end
   end

   assign rsp.anc_data = anc_zero_ff ? '0 : anc_q_ff;
   assign rsp.dep_data = dep_zero_ff ? '0 : dep_q_ff;

endmodule
`default_nettype wire

// ===== design/tlk_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlk_seq
// Sequencer: walks the ancestor table one lookup at a time for loads,
// lowest common ancestor and path node requests, and holds the result.
// ----------------------------------------------------------------------------
module tlk_seq import tlk_pkg::*; #(
   parameter int NODES  = 65536,
   parameter int LEVELS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tlk_req_if.sink     req_ch,
   tlk_rsp_if.source   rsp_ch,
   output mem_req_type mreq,
   input  wire mem_rsp_type mrsp
);
   localparam int IW = $clog2(LEVELS + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_L_DEP, S_L_DEPW, S_L_ANC, S_L_ANCW,
      S_Q_DU, S_Q_DV, S_Q_DVW, S_LIFT, S_LIFTW, S_CMP,
      S_UP_A, S_UP_B, S_UP_BW, S_PAR, S_PARW, S_LCA, S_DLW, S_SEL, S_OUT
   } state_type;

   state_type         state_ff;
   logic [1:0]        mode_ff;
   logic [NODE_W-1:0] u_ff, v_ff, k_ff, x_ff, b_ff, pa_ff, lca_ff;
   logic [NODE_W-1:0] du0_ff, du_ff, dv_ff, res_ff, ans_ff;
   logic [AMT_W-1:0]  amt_ff;
   logic [IW-1:0]     i_ff;
   logic              fin_ff, oor_ff, ans_oor_ff, rsp_valid_ff;
   logic              amt_bit;
   logic [NODE_W-1:0] load_depth, dl;
   logic [AMT_W-1:0]  path_len;

   assign amt_bit = |(amt_ff & (AMT_W'(1) << i_ff));
   assign load_depth = (v_ff == '0) ? NODE_W'(1) :
                       (mrsp.dep_data == '1) ? '1 : mrsp.dep_data + NODE_W'(1);
   assign dl       = mrsp.dep_data;
   assign path_len = AMT_W'(du_ff) + AMT_W'(dv_ff);

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_node = res_ff;
   assign rsp_ch.out_of_range = oor_ff;

   // memory port: at most one lookup issued per state, registered data back in the cycle after
   always_comb begin
      mreq = '0;
      case (state_ff)
         S_L_DEP: begin
            mreq.dep_rd  = 1'b1;
            mreq.rd_node = v_ff;
         end
         S_L_DEPW: begin
            mreq.dep_wr    = 1'b1;
            mreq.anc_wr    = 1'b1;
            mreq.wr_node   = u_ff;
            mreq.dep_wdata = load_depth;
            mreq.anc_wdata = v_ff;
         end
         S_L_ANC, S_LIFT, S_UP_A: begin
            mreq.anc_rd  = (state_ff != S_LIFT) || (amt_bit && i_ff != IW'(LEVELS));
            mreq.rd_node = x_ff;
            mreq.rd_lvl  = LVL_W'(i_ff);
         end
         S_L_ANCW: begin
            mreq.anc_wr    = 1'b1;
            mreq.wr_node   = u_ff;
            mreq.wr_lvl    = LVL_W'(i_ff + IW'(1));
            mreq.anc_wdata = mrsp.anc_data;
         end
         S_Q_DU: begin
            mreq.dep_rd  = 1'b1;
            mreq.rd_node = u_ff;
         end
         S_Q_DV: begin
            mreq.dep_rd  = 1'b1;
            mreq.rd_node = v_ff;
         end
         S_UP_B: begin
            mreq.anc_rd  = 1'b1;
            mreq.rd_node = b_ff;
            mreq.rd_lvl  = LVL_W'(i_ff);
         end
         S_PAR: begin
            mreq.anc_rd  = 1'b1;
            mreq.rd_node = x_ff;
         end
         S_LCA: begin
            mreq.dep_rd  = (mode_ff == MODE_PATH);
            mreq.rd_node = lca_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load the output register when it is free or being drained
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  mode_ff <= req_ch.mode;
                  u_ff    <= req_ch.node_u;
                  v_ff    <= req_ch.node_v;
                  k_ff    <= req_ch.offset_k;
                  case (req_ch.mode)
                     MODE_LOAD: begin
                        if (req_ch.node_u != '0 && 32'(req_ch.node_u) < 32'(NODES)) begin
                           state_ff <= S_L_DEP;
                        end
                     end
                     MODE_LCA, MODE_PATH: state_ff <= S_Q_DU;
                     default: ;
                  endcase
               end
            end
            S_L_DEP: state_ff <= S_L_DEPW;
            S_L_DEPW: begin
               x_ff     <= v_ff;
               i_ff     <= '0;
               state_ff <= (LEVELS == 1) ? S_IDLE : S_L_ANC;
            end
            S_L_ANC: state_ff <= S_L_ANCW;
            S_L_ANCW: begin
               x_ff <= mrsp.anc_data;
               i_ff <= i_ff + IW'(1);
               state_ff <= (i_ff + IW'(1) == IW'(LEVELS - 1)) ? S_IDLE : S_L_ANC;
            end
            S_Q_DU: state_ff <= S_Q_DV;
            S_Q_DV: begin
               du0_ff   <= mrsp.dep_data;
               state_ff <= S_Q_DVW;
            end
            S_Q_DVW: begin
               // deeper endpoint is lifted to the depth of the other
               if (du0_ff < mrsp.dep_data) begin
                  x_ff   <= v_ff;
                  b_ff   <= u_ff;
                  amt_ff <= AMT_W'(mrsp.dep_data - du0_ff);
               end else begin
                  x_ff   <= u_ff;
                  b_ff   <= v_ff;
                  amt_ff <= AMT_W'(du0_ff - mrsp.dep_data);
               end
               dv_ff    <= mrsp.dep_data;
               fin_ff   <= 1'b0;
               i_ff     <= '0;
               state_ff <= S_LIFT;
            end
            S_LIFT: begin
               if (i_ff == IW'(LEVELS)) begin
                  if (fin_ff) begin
                     ans_ff     <= x_ff;
                     ans_oor_ff <= 1'b0;
                     state_ff   <= S_OUT;
                  end else begin
                     state_ff <= S_CMP;
                  end
               end else if (amt_bit) begin
                  state_ff <= S_LIFTW;
               end else begin
                  i_ff <= i_ff + IW'(1);
               end
            end
            S_LIFTW: begin
               x_ff     <= mrsp.anc_data;
               i_ff     <= i_ff + IW'(1);
               state_ff <= S_LIFT;
            end
            S_CMP: begin
               if (x_ff == b_ff) begin
                  lca_ff   <= x_ff;
                  state_ff <= S_LCA;
               end else begin
                  i_ff     <= IW'(LEVELS - 1);
                  state_ff <= S_UP_A;
               end
            end
            S_UP_A: state_ff <= S_UP_B;
            S_UP_B: begin
               pa_ff    <= mrsp.anc_data;
               state_ff <= S_UP_BW;
            end
            S_UP_BW: begin
               if (pa_ff != mrsp.anc_data) begin
                  x_ff <= pa_ff;
                  b_ff <= mrsp.anc_data;
               end
               if (i_ff == '0) begin
                  state_ff <= S_PAR;
               end else begin
                  i_ff     <= i_ff - IW'(1);
                  state_ff <= S_UP_A;
               end
            end
            S_PAR: state_ff <= S_PARW;
            S_PARW: begin
               lca_ff   <= mrsp.anc_data;
               state_ff <= S_LCA;
            end
            S_LCA: begin
               if (mode_ff == MODE_PATH) begin
                  dv_ff    <= dv_ff;
                  state_ff <= S_DLW;
               end else begin
                  ans_ff     <= lca_ff;
                  ans_oor_ff <= 1'b0;
                  state_ff   <= S_OUT;
               end
            end
            S_DLW: begin
               du_ff    <= (du0_ff > dl) ? du0_ff - dl : '0;
               dv_ff    <= (dv_ff > dl) ? dv_ff - dl : '0;
               state_ff <= S_SEL;
            end
            S_SEL: begin
               fin_ff <= 1'b1;
               i_ff   <= '0;
               if (k_ff <= du_ff) begin
                  x_ff     <= u_ff;
                  amt_ff   <= AMT_W'(k_ff);
                  state_ff <= S_LIFT;
               end else if (AMT_W'(k_ff) <= path_len) begin
                  // walk down from v: lift v by what is left of the path
                  x_ff     <= v_ff;
                  amt_ff   <= path_len - AMT_W'(k_ff);
                  state_ff <= S_LIFT;
               end else begin
                  ans_ff     <= '0;
                  ans_oor_ff <= 1'b1;
                  state_ff   <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  res_ff   <= ans_ff;
                  oor_ff   <= ans_oor_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== design/tree_lca_kth_path_node.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tree_lca_kth_path_node
// Binary-lifting tree store with lowest common ancestor and path node lookup.
// ----------------------------------------------------------------------------
// One request at a time. Every table lookup is a read of the ancestor or depth
// memory, issued in one state and answered from a registered read in the next,
// so the sequencer's lookup chain sets the time. A finished result waits in the
// output register while the next request is taken. Parents must be loaded before
// their children, and only loaded nodes may be queried; node zero and nodes at or
// above NODES read as zero. Depth saturates at 65535.
module tree_lca_kth_path_node import tlk_pkg::*; #(
   parameter int NODES  = 65536,
   parameter int LEVELS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   tlk_req_if.sink   req_ch,
   tlk_rsp_if.source rsp_ch
);
   mem_req_type mreq;
   mem_rsp_type mrsp;

   tlk_mem #(.NODES(NODES), .LEVELS(LEVELS)) u_mem (
      .clock (clock),
      .req   (mreq),
      .rsp   (mrsp)
   );

   tlk_seq #(.NODES(NODES), .LEVELS(LEVELS)) u_seq (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .mreq   (mreq),
      .mrsp   (mrsp)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready &&
       (req_ch.mode == MODE_LCA || req_ch.mode == MODE_PATH)) |=> !req_ch.ready)
      else $error("request taken while another is in progress");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_of_range) |-> (rsp_ch.result_node == '0))
      else $error("out of range result carries a node");

endmodule
`default_nettype wire

// ===== tb/sv/tlk_tb_if.sv =====
// ----------------------------------------------------------------------------
// tlk_tb_if
// Channel interfaces for the tree ancestor testbench live with the design
// (tlk_req_if / tlk_rsp_if); this file carries the request and result record types.
// ----------------------------------------------------------------------------
package tlk_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]  mode;
      logic [15:0] node_u;
      logic [15:0] node_v;
      logic [15:0] offset_k;
      bit          drain_first;  // hold the request until no result is owed
   } tree_req_type;

   typedef struct {
      logic [15:0] result_node;
      logic        out_of_range;
   } path_result_type;
endpackage

// ===== tb/sv/tb_tree_lca_kth_path_node.sv =====
// ----------------------------------------------------------------------------
// tb_tree_lca_kth_path_node
// Loads random forests and checks ancestor and path node queries against an
// in-bench binary-lifting predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_tree_lca_kth_path_node;
   timeunit 1ns;
   timeprecision 1ps;
   import tlk_pkg::*;
   import tlk_tb_pkg::*;

   localparam int NODES     = 65536;
   localparam int LEVELS    = 16;
   localparam int LIMIT     = 3000000;
   localparam int CALM_LO   = 40000;
   localparam int CALM_HI   = 60000;
   localparam int HOLD_AT   = 8000;
   localparam int HOLD_LEN  = 700;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic clock;
   logic reset;

   tlk_req_if req_ch();
   tlk_rsp_if rsp_ch();

   tree_lca_kth_path_node #(.NODES(NODES), .LEVELS(LEVELS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bit [15:0]       anc_tab [0:NODES*LEVELS-1];
   bit [15:0]       dep_tab [0:NODES-1];
   tree_req_type    pending_reqs[$];
   path_result_type owed_results[$];
   int              cycle_count;
   int              fail_count;
   bit              req_fire;
   int              hold_left;

   // generator view of the forest
   bit [15:0]    loaded[$];
   bit           is_loaded [0:NODES-1];
   int           gen_depth [0:NODES-1];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned anc_of(int unsigned n, int unsigned lvl);
      if (n >= NODES || lvl >= LEVELS) return 0;
      return anc_tab[n*LEVELS + lvl];
   endfunction

   function automatic int unsigned depth_of(int unsigned n);
      if (n >= NODES) return 0;
      return dep_tab[n];
   endfunction

   function automatic int unsigned climb(int unsigned x, int unsigned amount);
      for (int i = 0; i < LEVELS; i++)
         if ((amount >> i) & 1) x = anc_of(x, i);
      return x;
   endfunction

   function automatic int unsigned common_ancestor(int unsigned a, int unsigned b);
      int unsigned da, db, t, pa, pb;
      da = depth_of(a);
      db = depth_of(b);
      if (da < db) begin
         t = a; a = b; b = t;
         t = da; da = db; db = t;
      end
      a = climb(a, da - db);
      if (a == b) return a;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         pa = anc_of(a, i);
         pb = anc_of(b, i);
         if (pa != pb) begin
            a = pa;
            b = pb;
         end
      end
      return anc_of(a, 0);
   endfunction

   task automatic apply_request(logic [1:0] mode, int unsigned u, int unsigned v,
                                int unsigned k);
      path_result_type r;
      int unsigned     d, up, l, dl, du, dv, path_len;
      r.out_of_range = 1'b0;
      if (mode == MODE_LOAD) begin
         if (u == 0 || u >= NODES) return;
         d = (v == 0) ? 1 : depth_of(v) + 1;
         if (d > 16'hFFFF) d = 16'hFFFF;
         dep_tab[u] = d[15:0];
         anc_tab[u*LEVELS] = v[15:0];
         for (int j = 0; j + 1 < LEVELS; j++) begin
            up = anc_tab[u*LEVELS + j];
            anc_tab[u*LEVELS + j + 1] = 16'(anc_of(up, j));
         end
      end else if (mode == MODE_LCA) begin
         r.result_node = 16'(common_ancestor(u, v));
         owed_results = {owed_results, r};
      end else if (mode == MODE_PATH) begin
         l        = common_ancestor(u, v);
         dl       = depth_of(l);
         du       = depth_of(u) > dl ? depth_of(u) - dl : 0;
         dv       = depth_of(v) > dl ? depth_of(v) - dl : 0;
         path_len = du + dv;
         if (k <= du) begin
            r.result_node = 16'(climb(u, k));
         end else if (k <= path_len) begin
            r.result_node = 16'(climb(v, path_len - k));
         end else begin
            r.result_node  = '0;
            r.out_of_range = 1'b1;
         end
         owed_results = {owed_results, r};
      end
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what,
               got, want);
      fail_count++;
   endtask

   function automatic bit calm();
      return cycle_count >= CALM_LO && cycle_count < CALM_HI;
   endfunction

   // cycle count, request acceptance, result check
   always @(posedge clock) begin
      path_result_type want;
      cycle_count <= cycle_count + 1;
      req_fire <= 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            apply_request(req_ch.mode, req_ch.node_u, req_ch.node_v, req_ch.offset_k);
            req_fire <= 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_ch.result_node, 0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_ch.result_node !== want.result_node)
                  report_mismatch("result_node", rsp_ch.result_node, want.result_node);
               if (rsp_ch.out_of_range !== want.out_of_range)
                  report_mismatch("out_of_range", rsp_ch.out_of_range, want.out_of_range);
            end
         end
      end
      if (cycle_count >= LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // request driver
   always @(negedge clock) begin
      tree_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (pending_reqs.size() == 0 || (!calm() && $urandom_range(0, 99) < 36)) begin
            req_ch.valid <= 1'b0;
         end else if (pending_reqs[0].drain_first && owed_results.size() != 0) begin
            req_ch.valid <= 1'b0;
         end else begin
            nxt = pending_reqs.pop_front();
            req_ch.valid    <= 1'b1;
            req_ch.mode     <= nxt.mode;
            req_ch.node_u   <= nxt.node_u;
            req_ch.node_v   <= nxt.node_v;
            req_ch.offset_k <= nxt.offset_k;
         end
      end
   end

   // result receiver, with one long hold-off
   always @(negedge clock) begin
      if (cycle_count == HOLD_AT) hold_left <= HOLD_LEN;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      if (reset || hold_left > 0 || cycle_count == HOLD_AT)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= calm() ? 1'b1 : ($urandom_range(0, 99) >= 36);
   end

   task automatic queue_req(logic [1:0] mode, int unsigned u, int unsigned v,
                            int unsigned k, bit drain = 0);
      tree_req_type t;
      t.mode = mode;
      t.node_u = u;
      t.node_v = v;
      t.offset_k = k;
      t.drain_first = drain;
      pending_reqs = {pending_reqs, t};
      if (mode == MODE_LOAD && u != 0) begin
         if (!is_loaded[u]) loaded = {loaded, 16'(u)};
         is_loaded[u] = 1'b1;
         gen_depth[u] = (v == 0) ? 1 : gen_depth[v] + 1;
      end
   endtask

   function automatic int unsigned pick_loaded();
      if ($urandom_range(0, 1)) return loaded[loaded.size() - 1 - $urandom_range(0,
         (loaded.size() > 8 ? 7 : loaded.size() - 1))];
      return loaded[$urandom_range(0, loaded.size() - 1)];
   endfunction

   function automatic int unsigned fresh_node();
      int unsigned n;
      do n = $urandom_range(1, 65535); while (is_loaded[n]);
      return n;
   endfunction

   task automatic queue_query();
      int unsigned u, v, k, span;
      u = pick_loaded();
      v = ($urandom_range(0, 9) == 0) ? u : pick_loaded();
      span = gen_depth[u] + gen_depth[v];
      case ($urandom_range(0, 5))
         0:       k = $urandom_range(0, 65535);
         1:       k = (span > 65535) ? 65535 : span;
         default: k = $urandom_range(0, span > 65534 ? 65535 : span + 1);
      endcase
      queue_req(($urandom_range(0, 1) ? MODE_PATH : MODE_LCA), u, v, k);
   endtask

   initial begin
      int unsigned p, sel;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_LOAD;
      req_ch.node_u = '0;
      req_ch.node_v = '0;
      req_ch.offset_k = '0;
      rsp_ch.ready = 1'b0;
      cycle_count = 0;
      fail_count = 0;
      hold_left = 0;
      req_fire = 1'b0;
      reset = 1'b1;

      // directed: two trees, a short chain and a side branch
      queue_req(MODE_LOAD, 1, 0, 16'hFFFF);
      queue_req(MODE_LOAD, 16'hFFFF, 0, 0);
      queue_req(MODE_LOAD, 16'h8000, 1, 0);
      queue_req(MODE_LOAD, 16'h7FFF, 16'h8000, 0);
      queue_req(MODE_LOAD, 16'h5555, 16'h7FFF, 0);
      queue_req(MODE_LOAD, 16'hAAAA, 16'h5555, 0);
      queue_req(MODE_LOAD, 16'h0002, 16'h8000, 0);
      queue_req(MODE_LOAD, 0, 16'hAAAA, 0);        // node zero: ignored
      queue_req(MODE_UNUSED, 16'hAAAA, 1, 5);      // unused mode: ignored
      queue_req(MODE_LCA, 16'hAAAA, 16'h0002, 0);
      queue_req(MODE_LCA, 16'hAAAA, 16'hFFFF, 0);  // different trees
      queue_req(MODE_LCA, 1, 1, 0);
      queue_req(MODE_LCA, 16'h5555, 1, 0);
      queue_req(MODE_PATH, 16'hAAAA, 16'h0002, 0);
      queue_req(MODE_PATH, 16'hAAAA, 16'h0002, 4);
      queue_req(MODE_PATH, 16'hAAAA, 16'h0002, 5);
      queue_req(MODE_PATH, 16'hAAAA, 16'h0002, 6);
      queue_req(MODE_PATH, 16'h0002, 16'hAAAA, 3);
      queue_req(MODE_PATH, 16'hAAAA, 16'hFFFF, 2);
      queue_req(MODE_PATH, 1, 1, 0);
      queue_req(MODE_PATH, 1, 1, 1);
      queue_req(MODE_PATH, 16'hAAAA, 1, 16'hFFFF);

      for (int n = 0; n < 1700; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 25 || loaded.size() < 4) begin
            p = ($urandom_range(0, 19) == 0) ? 0 : pick_loaded();
            queue_req(MODE_LOAD, fresh_node(), p, $urandom_range(0, 65535));
         end else if (sel < 28) begin
            // reload an existing node under some loaded parent
            p = pick_loaded();
            queue_req(MODE_LOAD, pick_loaded(), p, 0);
         end else if (sel < 30) begin
            queue_req(($urandom_range(0, 1) ? MODE_UNUSED : MODE_LOAD),
                      ($urandom_range(0, 1) ? 0 : pick_loaded()),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
            if (pending_reqs[$].mode == MODE_LOAD) pending_reqs[$].node_u = 0;
         end else begin
            queue_query();
         end
         if (n % 400 == 200) pending_reqs[$].drain_first = 1'b1;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0 && !req_ch.valid);
      wait (owed_results.size() == 0);
      repeat (300) @(posedge clock);
      if (owed_results.size() != 0) begin
         $display("MISMATCH: %0d results never arrived", owed_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
